/* src/amrp_pkg.sv */
// Shared types and constants for the advertising manufacturer record parser.
// Used by the front, queue, back and top-level files; no dependencies.
package amrp_pkg;

  localparam int MAX_REPORT_BYTES_DEF = 255;

  // Configuration register indexes
  localparam logic REG_COMPANY = 1'b0;
  localparam logic REG_APP     = 1'b1;
  localparam int   CFG_IDX_W   = 1;
  localparam int   CFG_DATA_W  = 16;

  localparam logic [15:0] COMPANY_RST = 16'h6FAF;
  localparam logic [7:0]  APP_RST     = 8'hAA;

  localparam logic [7:0] MFR_TYPE        = 8'hFF;
  localparam logic [7:0] MIN_RECORD_DATA = 8'd12;

  // Servo pulse: PULSE_MIN + (PULSE_MAX - PULSE_MIN) * angle / ANGLE_SPAN
  localparam int PULSE_MIN   = 1000;
  localparam int PULSE_MAX   = 2000;
  localparam int ANGLE_SPAN  = 90;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 22;
  localparam logic [RECIP_W-1:0] PULSE_RECIP =
    RECIP_W'(((PULSE_MAX - PULSE_MIN) * (1 << RECIP_SHIFT) + ANGLE_SPAN - 1) / ANGLE_SPAN);

  // Queue between front and back
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [15:0] company;
    logic [7:0]  app;
  } cfg_t;

  // Matched record: payload bytes 0-7 and the final payload byte
  typedef struct packed {
    logic [7:0][7:0] cap;
    logic [7:0]      last;
  } rec_t;

endpackage

/* src/adv_manufacturer_record_parser.sv */
// Top level of the advertising manufacturer record parser: config registers,
// front parser, record queue and decode back end. Depends on amrp_pkg.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   data_byte, bytes_after, report_start
//   out_     output     out_valid/out_stall co2, humidity, temperature, angle,
//                                           range, pulse_us
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte is accepted per cycle unless in_stall is high; out_valid for a
// matched record rises after its queue write and the output register load.
// in_stall rises only while the two-entry record queue is full.
// Reset is synchronous, active low; registers restart at their reset values.
// cfg_ready is always high; a write takes effect on the next byte.
module adv_manufacturer_record_parser #(
  parameter int MAX_REPORT_BYTES = amrp_pkg::MAX_REPORT_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  input  logic [7:0]                      in_bytes_after,
  input  logic                            in_report_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     out_co2_level,
  output logic [15:0]                     out_humidity_level,
  output logic [15:0]                     out_temperature_level,
  output logic [7:0]                      out_servo_angle,
  output logic [15:0]                     out_range_reading,
  output logic [11:0]                     out_pulse_us,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [amrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amrp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import amrp_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_full, push, rec_valid, rec_pop, byte_accept;
  rec_t push_rec, pop_rec;

  assign cfg_ready   = 1'b1;
  assign in_stall    = q_full;
  assign byte_accept = in_valid && !in_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COMPANY: cfg_nxt.company = cfg_data[15:0];
        REG_APP:     cfg_nxt.app     = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.company <= COMPANY_RST;
      cfg_r.app     <= APP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  amrp_front #(
    .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_accept  (byte_accept),
    .data_byte    (in_data_byte),
    .bytes_after  (in_bytes_after),
    .report_start (in_report_start),
    .cfg          (cfg_r),
    .push         (push),
    .push_rec     (push_rec)
  );

  amrp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (rec_pop),
    .pop_valid (rec_valid),
    .pop_rec   (pop_rec)
  );

  amrp_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .rec_valid             (rec_valid),
    .rec                   (pop_rec),
    .rec_pop               (rec_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_co2_level         (out_co2_level),
    .out_humidity_level    (out_humidity_level),
    .out_temperature_level (out_temperature_level),
    .out_servo_angle       (out_servo_angle),
    .out_range_reading     (out_range_reading),
    .out_pulse_us          (out_pulse_us)
  );

endmodule

/* src/amrp_front.sv */
// Front end: walks the length-type-value structures byte by byte and pushes
// matched manufacturer records into the queue. Depends on amrp_pkg.
module amrp_front #(
  parameter int MAX_REPORT_BYTES = amrp_pkg::MAX_REPORT_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_accept,
  input  logic [7:0]        data_byte,
  input  logic [7:0]        bytes_after,
  input  logic              report_start,
  input  amrp_pkg::cfg_t    cfg,
  output logic              push,
  output amrp_pkg::rec_t    push_rec
);
  import amrp_pkg::*;

  localparam logic [1:0] PH_LENGTH = 2'd0;
  localparam logic [1:0] PH_TYPE   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  localparam logic [7:0] BA_CAP = 8'(MAX_REPORT_BYTES - 1);

  localparam logic [7:0] OFF_CO_LO     = 8'd0;
  localparam logic [7:0] OFF_CO_HI     = 8'd1;
  localparam logic [7:0] OFF_APP       = 8'd2;
  localparam logic [7:0] OFF_CAP_FIRST = 8'd3;
  localparam logic [7:0] OFF_CAP_LAST  = 8'd10;
  localparam logic [7:0] OFF_FINAL     = 8'd11;

  logic [1:0]      phase_r, phase_nxt, phase_cur;
  logic [7:0]      rem_r, rem_nxt, rem_dec;
  logic [7:0]      off_r, off_nxt, off_cap;
  logic            cand_r, cand_nxt, cand_cur;
  logic            match_r, match_nxt, match_cur;
  logic [7:0][7:0] cap_r, cap_nxt;
  logic [7:0]      ba_sat;

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    off_nxt   = off_r;
    cand_nxt  = cand_r;
    match_nxt = match_r;
    cap_nxt   = cap_r;
    push      = 1'b0;
    ba_sat    = (bytes_after > BA_CAP) ? BA_CAP : bytes_after;
    rem_dec   = rem_r - 8'd1;
    off_cap   = off_r - OFF_CAP_FIRST;
    phase_cur = report_start ? PH_LENGTH : phase_r;
    cand_cur  = report_start ? 1'b0 : cand_r;
    match_cur = report_start ? 1'b0 : match_r;
    if (byte_accept) begin
      cand_nxt  = cand_cur;
      match_nxt = match_cur;
      phase_nxt = phase_cur;
      unique case (phase_cur)
        PH_LENGTH: begin
          if (ba_sat == 8'd0 || data_byte == 8'd0 || data_byte > ba_sat) begin
            phase_nxt = PH_STOP;
          end else begin
            rem_nxt   = data_byte;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          rem_nxt   = rem_dec;
          cand_nxt  = (data_byte == MFR_TYPE) && (rem_dec >= MIN_RECORD_DATA);
          match_nxt = 1'b1;
          off_nxt   = 8'd0;
          phase_nxt = (rem_dec != 8'd0) ? PH_DATA : PH_LENGTH;
        end
        PH_DATA: begin
          if (cand_cur) begin
            case (off_r) inside
              OFF_CO_LO: match_nxt = match_cur && (data_byte == cfg.company[7:0]);
              OFF_CO_HI: match_nxt = match_cur && (data_byte == cfg.company[15:8]);
              OFF_APP:   match_nxt = match_cur && (data_byte == cfg.app);
              [OFF_CAP_FIRST:OFF_CAP_LAST]: cap_nxt[off_cap[2:0]] = data_byte;
              OFF_FINAL: push = match_cur;
              default: ;
            endcase
          end
          off_nxt = off_r + 8'd1;
          rem_nxt = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_nxt = PH_LENGTH;
          end
        end
        PH_STOP: ;
        default: ;
      endcase
      // the final byte of a report always stops parsing
      if (ba_sat == 8'd0) begin
        phase_nxt = PH_STOP;
      end
    end
  end

  assign push_rec.cap  = cap_r;
  assign push_rec.last = data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LENGTH;
      rem_r   <= 8'd0;
      off_r   <= 8'd0;
      cand_r  <= 1'b0;
      match_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      off_r   <= off_nxt;
      cand_r  <= cand_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r <= cap_nxt;
  end

  a_push_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> byte_accept && phase_cur == PH_DATA && cand_cur && off_r == OFF_FINAL)
    else $error("record pushed outside the final payload byte");

  a_final_stops: assert property (@(posedge clk) disable iff (!rst_n)
    byte_accept && bytes_after == 8'd0 |=> phase_r == PH_STOP)
    else $error("parser not stopped after final byte");

  a_type_resets_off: assert property (@(posedge clk) disable iff (!rst_n)
    byte_accept && phase_cur == PH_TYPE |=> off_r == 8'd0 && match_r)
    else $error("type byte did not reset offset and match");

endmodule

/* src/amrp_fifo.sv */
// Short record queue between the parser front and the decode back end.
// Depends on amrp_pkg for the record type and depth.
module amrp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  amrp_pkg::rec_t  push_rec,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output amrp_pkg::rec_t  pop_rec
);
  import amrp_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  rec_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign pop_valid = (cnt_r != '0);
  assign pop_rec   = mem_r[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("record pushed into a full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count past depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");

endmodule

/* src/amrp_back.sv */
// Back end: pops a matched record, decodes the readings and the servo pulse,
// and holds the result in the output register. Depends on amrp_pkg.
module amrp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rec_valid,
  input  amrp_pkg::rec_t  rec,
  output logic            rec_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [15:0]     out_co2_level,
  output logic [15:0]     out_humidity_level,
  output logic [15:0]     out_temperature_level,
  output logic [7:0]      out_servo_angle,
  output logic [15:0]     out_range_reading,
  output logic [11:0]     out_pulse_us
);
  import amrp_pkg::*;

  localparam int PROD_W = 8 + RECIP_W;

  logic              valid_r, valid_nxt;
  logic [PROD_W-1:0] prod;
  logic [11:0]       pulse;
  logic [15:0]       co2_r, hum_r, temp_r, range_r;
  logic [7:0]        angle_r;
  logic [11:0]       pulse_r;

  // load whenever the output register is empty or being drained
  assign rec_pop   = rec_valid && (!valid_r || !out_stall);
  assign valid_nxt = rec_pop ? 1'b1 : (valid_r && out_stall);

  // divide by the angle span through a scaled reciprocal
  assign prod  = PROD_W'(rec.cap[6]) * PROD_W'(PULSE_RECIP);
  assign pulse = 12'(PULSE_MIN) + prod[RECIP_SHIFT +: 12];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      co2_r   <= {rec.cap[1], rec.cap[0]};
      hum_r   <= {rec.cap[3], rec.cap[2]};
      temp_r  <= {rec.cap[5], rec.cap[4]};
      angle_r <= rec.cap[6];
      range_r <= {rec.last, rec.cap[7]};
      pulse_r <= pulse;
    end
  end

  assign out_valid             = valid_r;
  assign out_co2_level         = co2_r;
  assign out_humidity_level    = hum_r;
  assign out_temperature_level = temp_r;
  assign out_servo_angle       = angle_r;
  assign out_range_reading     = range_r;
  assign out_pulse_us          = pulse_r;

endmodule
